// ----- rtl/core/e2c_pkg.sv -----
package e2c_pkg;

    // Field widths
    localparam int SRC_W    = 13;
    localparam int FACE_W   = 3;
    localparam int COORD_W  = 10;
    localparam int ADDR_W   = 12;
    localparam int WEIGHT_W = 16;

    // Configuration limits and reset values
    localparam int MIN_SRC_WIDTH  = 4;
    localparam int MAX_SRC_HEIGHT = 4096;
    localparam int RESET_WIDTH    = 1024;
    localparam int RESET_HEIGHT   = 512;

    localparam int DEF_CORDIC_STAGES = 16;
    localparam int DEF_MAX_SRC_WIDTH = 4096;

    // Face size divider: quotient is col * 2^17 / F, col below F
    localparam int F_W       = SRC_W - 2;
    localparam int REM_W     = F_W + 1;
    localparam int DIV_STEPS = 17;
    localparam int ONE16     = 65536;

    // Direction in Q2.16
    localparam int DIR_W = 18;
    localparam int MAG_W = 17;
    localparam int SQR_W = 2 * MAG_W;

    // Radius: integer root of (x^2 + y^2) in Q.48
    localparam int SQ_N_W   = 50;
    localparam int SQ_R_W   = 25;
    localparam int SQ_STEPS = 25;

    // CORDIC datapath and angle in units of 2^-24 turn
    localparam int CW     = 28;
    localparam int ZW     = 26;
    localparam int TURN_W = 24;
    localparam int MUL_W  = TURN_W + SRC_W;

    typedef enum logic [0:0] {
        REG_SRC_WIDTH  = 1'b0,
        REG_SRC_HEIGHT = 1'b1
    } cfg_reg_t;

    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;

    typedef struct packed {
        logic [FACE_W-1:0]  face;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } in_item_t;

    typedef struct packed {
        logic [FACE_W-1:0]   out_face;
        logic [COORD_W-1:0]  out_col;
        logic [COORD_W-1:0]  out_row;
        logic [ADDR_W-1:0]   u_near;
        logic [ADDR_W-1:0]   u_far;
        logic [ADDR_W-1:0]   v_near;
        logic [ADDR_W-1:0]   v_far;
        logic [WEIGHT_W-1:0] s_weight;
        logic [WEIGHT_W-1:0] t_weight;
    } out_item_t;

    typedef struct packed {
        logic signed [DIR_W-1:0] px;
        logic signed [DIR_W-1:0] py;
        logic signed [DIR_W-1:0] pz;
    } dir_t;

    typedef struct packed {
        logic [SRC_W-1:0] w_eff;
        logic [SRC_W-1:0] h_eff;
    } cfg_t;

    // Rounded arctangent of 2^-i in units of 2^-24 turn
    function automatic logic signed [ZW-1:0] atan_turn(input int idx);
        logic signed [ZW-1:0] val;
        case (idx)
            0:  val = ZW'(2097152);
            1:  val = ZW'(1238021);
            2:  val = ZW'(654136);
            3:  val = ZW'(332050);
            4:  val = ZW'(166669);
            5:  val = ZW'(83416);
            6:  val = ZW'(41718);
            7:  val = ZW'(20860);
            8:  val = ZW'(10430);
            9:  val = ZW'(5215);
            10: val = ZW'(2608);
            11: val = ZW'(1304);
            12: val = ZW'(652);
            13: val = ZW'(326);
            14: val = ZW'(163);
            15: val = ZW'(81);
            16: val = ZW'(41);
            17: val = ZW'(20);
            18: val = ZW'(10);
            19: val = ZW'(5);
            20: val = ZW'(3);
            21: val = ZW'(1);
            22: val = ZW'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ----- rtl/core/equirect_to_cubemap_sample_address.sv -----
// Bilinear sample address generator, equirectangular source to cubemap
// destination. One texel beat is taken every cycle unless the output
// buffer is full, and one result beat leaves per texel, in order. The
// pipeline is one input stage, 17 stages of the face-size divider, one
// squaring stage and 25 root stages, one fold stage plus one stage per
// CORDIC iteration, three scaling stages and a two-beat output buffer.
// The pipeline holds as a whole only while that buffer is full, so
// in_ready depends on buffer state alone. Configuration writes go through
// the raw and clamped registers and are meant for an empty pipeline.
module equirect_to_cubemap_sample_address
    import e2c_pkg::*;
#(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
    parameter int MAX_SRC_WIDTH = DEF_MAX_SRC_WIDTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data,
    input  logic             cfg_we,
    input  cfg_reg_t         cfg_index,
    input  logic [SRC_W-1:0] cfg_data
);

    localparam logic signed [DIR_W-1:0] DIR_ONE = DIR_W'(ONE16);

    logic [SRC_W-1:0]  width_reg;
    logic [SRC_W-1:0]  height_reg;
    logic [SRC_W-1:0]  w_eff_next;
    logic [SRC_W-1:0]  h_eff_next;
    logic [SRC_W-1:0]  w_eff_reg;
    logic [SRC_W-1:0]  h_eff_reg;
    logic [F_W-1:0]    f_reg;
    cfg_t              cfg;

    logic              advance;
    logic [F_W-1:0]    fm1;
    logic [F_W-1:0]    col_ext;
    logic [F_W-1:0]    row_ext;
    logic              s0_valid_reg;
    in_item_t          s0_tag_reg;
    logic [1:0][F_W-1:0] s0_num_reg;

    logic                       div_valid;
    in_item_t                   div_tag;
    logic [1:0][DIV_STEPS-1:0]  div_quo;
    logic signed [DIR_W-1:0]    dir_a;
    logic signed [DIR_W-1:0]    dir_b;
    dir_t                       dir_sel;

    logic              sq_valid;
    in_item_t          sq_tag;
    dir_t              sq_dir;
    logic [SQ_R_W-1:0] sq_r;

    logic signed [CW-1:0] cor_y [2];
    logic signed [CW-1:0] cor_x [2];
    logic                 cor_valid;
    in_item_t             cor_tag;
    logic signed [ZW-1:0] cor_z [2];

    logic              map_valid;
    out_item_t         map_item;

    out_item_t         fifo_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        fifo_cnt_reg;
    logic              push;
    logic              pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SRC_W'(RESET_WIDTH);
            height_reg <= SRC_W'(RESET_HEIGHT);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SRC_WIDTH:  width_reg  <= cfg_data;
                REG_SRC_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // Clamp width and height, derive the face size
    always_comb
    begin
        if (width_reg < SRC_W'(MIN_SRC_WIDTH))
            w_eff_next = SRC_W'(MIN_SRC_WIDTH);
        else if (32'(width_reg) > MAX_SRC_WIDTH)
            w_eff_next = SRC_W'(MAX_SRC_WIDTH);
        else
            w_eff_next = width_reg;

        if (height_reg == '0)
            h_eff_next = SRC_W'(1);
        else if (height_reg > SRC_W'(MAX_SRC_HEIGHT))
            h_eff_next = SRC_W'(MAX_SRC_HEIGHT);
        else
            h_eff_next = height_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg <= SRC_W'(RESET_WIDTH);
            h_eff_reg <= SRC_W'(RESET_HEIGHT);
            f_reg     <= F_W'(RESET_WIDTH / 4);
        end
        else
        begin
            w_eff_reg <= w_eff_next;
            h_eff_reg <= h_eff_next;
            f_reg     <= w_eff_next[SRC_W-1:2];
        end
    end

    assign cfg.w_eff = w_eff_reg;
    assign cfg.h_eff = h_eff_reg;

    // Whole pipeline moves unless the output buffer is full
    assign advance  = (fifo_cnt_reg != 2'd2);
    assign in_ready = advance;

    // Input stage: saturate column and row to the face
    assign fm1     = f_reg - F_W'(1);
    assign col_ext = F_W'(in_data.col);
    assign row_ext = F_W'(in_data.row);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_valid_reg <= 1'b0;
        else if (advance)
            s0_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_tag_reg    <= in_data;
            s0_num_reg[0] <= (col_ext > fm1) ? fm1 : col_ext;
            s0_num_reg[1] <= (row_ext > fm1) ? fm1 : row_ext;
        end
    end

    e2c_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (s0_valid_reg),
        .in_tag    (s0_tag_reg),
        .in_num    (s0_num_reg),
        .den       (f_reg),
        .out_valid (div_valid),
        .out_tag   (div_tag),
        .out_quo   (div_quo)
    );

    // Face direction in Q2.16
    assign dir_a = $signed({1'b0, div_quo[0]}) - DIR_ONE;
    assign dir_b = $signed({1'b0, div_quo[1]}) - DIR_ONE;

    always_comb
    begin
        case (div_tag.face)
            FACE_POS_X:
            begin
                dir_sel.px = dir_a;
                dir_sel.py = DIR_ONE;
                dir_sel.pz = -dir_b;
            end
            FACE_NEG_X:
            begin
                dir_sel.px = -dir_a;
                dir_sel.py = -DIR_ONE;
                dir_sel.pz = -dir_b;
            end
            FACE_POS_Y:
            begin
                dir_sel.px = -dir_b;
                dir_sel.py = dir_a;
                dir_sel.pz = DIR_ONE;
            end
            FACE_NEG_Y:
            begin
                dir_sel.px = dir_b;
                dir_sel.py = dir_a;
                dir_sel.pz = -DIR_ONE;
            end
            FACE_POS_Z:
            begin
                dir_sel.px = -DIR_ONE;
                dir_sel.py = dir_a;
                dir_sel.pz = -dir_b;
            end
            default:
            begin
                dir_sel.px = DIR_ONE;
                dir_sel.py = -dir_a;
                dir_sel.pz = -dir_b;
            end
        endcase
    end

    e2c_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (div_valid),
        .in_tag    (div_tag),
        .in_dir    (dir_sel),
        .out_valid (sq_valid),
        .out_tag   (sq_tag),
        .out_dir   (sq_dir),
        .out_r     (sq_r)
    );

    // Widen to Q.24: lane 0 is longitude, lane 1 latitude
    assign cor_x[0] = {{(CW-DIR_W-8){sq_dir.px[DIR_W-1]}}, sq_dir.px, 8'b0};
    assign cor_y[0] = {{(CW-DIR_W-8){sq_dir.py[DIR_W-1]}}, sq_dir.py, 8'b0};
    assign cor_x[1] = {{(CW-SQ_R_W){1'b0}}, sq_r};
    assign cor_y[1] = {{(CW-DIR_W-8){sq_dir.pz[DIR_W-1]}}, sq_dir.pz, 8'b0};

    e2c_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (sq_valid),
        .in_tag    (sq_tag),
        .in_y      (cor_y),
        .in_x      (cor_x),
        .out_valid (cor_valid),
        .out_tag   (cor_tag),
        .out_z     (cor_z)
    );

    e2c_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (cor_valid),
        .in_tag    (cor_tag),
        .in_phi    (cor_z[0]),
        .in_theta  (cor_z[1]),
        .cfg       (cfg),
        .out_valid (map_valid),
        .out_item  (map_item)
    );

    // Two-beat output buffer
    assign push      = advance && map_valid;
    assign pop       = out_valid && out_ready;
    assign out_valid = (fifo_cnt_reg != 2'd0);
    assign out_data  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            fifo_cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                fifo_cnt_reg <= fifo_cnt_reg + 2'd1;
            else if (pop && !push)
                fifo_cnt_reg <= fifo_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= map_item;
    end

    // Checks
    assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg != 2'd3)
        else $error("output buffer count overflow");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.v_far == out_data.v_near ||
                       out_data.v_far == out_data.v_near + 12'd1))
        else $error("row neighbours more than one apart");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, out_data.v_far} < h_eff_reg))
        else $error("far row beyond source height");

endmodule

// ----- rtl/core/e2c_div.sv -----
module e2c_div
    import e2c_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  logic                       in_valid,
    input  in_item_t                   in_tag,
    input  logic [1:0][F_W-1:0]        in_num,
    input  logic [F_W-1:0]             den,
    output logic                       out_valid,
    output in_item_t                   out_tag,
    output logic [1:0][DIV_STEPS-1:0]  out_quo
);

    logic                      valid_reg [DIV_STEPS];
    in_item_t                  tag_reg   [DIV_STEPS];
    logic [1:0][REM_W-1:0]     rem_reg   [DIV_STEPS];
    logic [1:0][DIV_STEPS-1:0] quo_reg   [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic                      valid_in;
        in_item_t                  tag_in;
        logic [1:0][REM_W-1:0]     rem_in;
        logic [1:0][REM_W-1:0]     rem_next;
        logic [1:0][DIV_STEPS-1:0] quo_in;
        logic [1:0][DIV_STEPS-1:0] quo_next;

        if (k == 0) begin : g_head
            assign valid_in  = in_valid;
            assign tag_in    = in_tag;
            assign rem_in[0] = REM_W'(in_num[0]);
            assign rem_in[1] = REM_W'(in_num[1]);
            assign quo_in    = '0;
        end else begin : g_body
            assign valid_in = valid_reg[k-1];
            assign tag_in   = tag_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign quo_in   = quo_reg[k-1];
        end

        // One restoring step per lane: double, trial subtract
        always_comb
        begin
            logic [REM_W-1:0] dbl;
            dbl = '0;
            for (int l = 0; l < 2; l++)
            begin
                dbl = {rem_in[l][REM_W-2:0], 1'b0};
                if (dbl >= REM_W'(den))
                begin
                    rem_next[l] = dbl - REM_W'(den);
                    quo_next[l] = {quo_in[l][DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_next[l] = dbl;
                    quo_next[l] = {quo_in[l][DIV_STEPS-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (advance)
                valid_reg[k] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                tag_reg[k] <= tag_in;
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
            end
        end
    end

    assign out_valid = valid_reg[DIV_STEPS-1];
    assign out_tag   = tag_reg[DIV_STEPS-1];
    assign out_quo   = quo_reg[DIV_STEPS-1];

endmodule

// ----- rtl/core/e2c_sqrt.sv -----
module e2c_sqrt
    import e2c_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              in_valid,
    input  in_item_t          in_tag,
    input  dir_t              in_dir,
    output logic              out_valid,
    output in_item_t          out_tag,
    output dir_t              out_dir,
    output logic [SQ_R_W-1:0] out_r
);

    logic               sq_valid_reg;
    in_item_t           sq_tag_reg;
    dir_t               sq_dir_reg;
    logic [SQR_W-1:0]   sqx_reg;
    logic [SQR_W-1:0]   sqy_reg;
    logic [MAG_W-1:0]   mag_x;
    logic [MAG_W-1:0]   mag_y;
    logic [DIR_W-1:0]   neg_x;
    logic [DIR_W-1:0]   neg_y;

    logic               valid_reg [SQ_STEPS];
    in_item_t           tag_reg   [SQ_STEPS];
    dir_t               dir_reg   [SQ_STEPS];
    logic [SQ_N_W-1:0]  rem_reg   [SQ_STEPS];
    logic [SQ_N_W-1:0]  res_reg   [SQ_STEPS];

    // Square the magnitudes of x and y
    assign neg_x = -in_dir.px;
    assign neg_y = -in_dir.py;
    assign mag_x = in_dir.px[DIR_W-1] ? neg_x[MAG_W-1:0] : in_dir.px[MAG_W-1:0];
    assign mag_y = in_dir.py[DIR_W-1] ? neg_y[MAG_W-1:0] : in_dir.py[MAG_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else if (advance)
            sq_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_tag_reg <= in_tag;
            sq_dir_reg <= in_dir;
            sqx_reg    <= mag_x * mag_x;
            sqy_reg    <= mag_y * mag_y;
        end
    end

    // Digit-by-digit root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
        localparam logic [SQ_N_W-1:0] BIT = SQ_N_W'(1) << (2 * (SQ_STEPS - 1 - k));
        logic              valid_in;
        in_item_t          tag_in;
        dir_t              dir_in;
        logic [SQ_N_W-1:0] rem_in;
        logic [SQ_N_W-1:0] res_in;
        logic [SQ_N_W-1:0] trial;
        logic              fits;

        if (k == 0) begin : g_head
            assign valid_in = sq_valid_reg;
            assign tag_in   = sq_tag_reg;
            assign dir_in   = sq_dir_reg;
            assign rem_in   = SQ_N_W'({1'b0, sqx_reg} + {1'b0, sqy_reg}) << 16;
            assign res_in   = '0;
        end else begin : g_body
            assign valid_in = valid_reg[k-1];
            assign tag_in   = tag_reg[k-1];
            assign dir_in   = dir_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign res_in   = res_reg[k-1];
        end

        assign trial = res_in + BIT;
        assign fits  = rem_in >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (advance)
                valid_reg[k] <= valid_in;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                tag_reg[k] <= tag_in;
                dir_reg[k] <= dir_in;
                rem_reg[k] <= fits ? rem_in - trial : rem_in;
                res_reg[k] <= fits ? (res_in >> 1) + BIT : res_in >> 1;
            end
        end
    end

    assign out_valid = valid_reg[SQ_STEPS-1];
    assign out_tag   = tag_reg[SQ_STEPS-1];
    assign out_dir   = dir_reg[SQ_STEPS-1];
    assign out_r     = res_reg[SQ_STEPS-1][SQ_R_W-1:0];

endmodule

// ----- rtl/core/e2c_cordic.sv -----
module e2c_cordic
    import e2c_pkg::*;
#(
    parameter int STAGES = DEF_CORDIC_STAGES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  in_item_t             in_tag,
    input  logic signed [CW-1:0] in_y [2],
    input  logic signed [CW-1:0] in_x [2],
    output logic                 out_valid,
    output in_item_t             out_tag,
    output logic signed [ZW-1:0] out_z [2]
);

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(2 ** (TURN_W - 1));

    logic                 valid_reg [STAGES+1];
    in_item_t             tag_reg   [STAGES+1];
    logic signed [CW-1:0] x_reg     [STAGES+1][2];
    logic signed [CW-1:0] y_reg     [STAGES+1][2];
    logic signed [ZW-1:0] z_reg     [STAGES+1][2];
    logic                 zero_reg  [STAGES+1][2];

    // Fold the left half plane onto the right, flag the zero vector
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg[0] <= 1'b0;
        else if (advance)
            valid_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tag_reg[0] <= in_tag;
            for (int l = 0; l < 2; l++)
            begin
                zero_reg[0][l] <= (in_x[l] == '0) && (in_y[l] == '0);
                if (in_x[l][CW-1])
                begin
                    x_reg[0][l] <= -in_x[l];
                    y_reg[0][l] <= -in_y[l];
                    z_reg[0][l] <= in_y[l][CW-1] ? -HALF_TURN : HALF_TURN;
                end
                else
                begin
                    x_reg[0][l] <= in_x[l];
                    y_reg[0][l] <= in_y[l];
                    z_reg[0][l] <= '0;
                end
            end
        end
    end

    // Vectoring stages: drive y towards zero
    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        localparam logic signed [ZW-1:0] ANGLE = atan_turn(k);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k+1] <= 1'b0;
            else if (advance)
                valid_reg[k+1] <= valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                tag_reg[k+1] <= tag_reg[k];
                for (int l = 0; l < 2; l++)
                begin
                    zero_reg[k+1][l] <= zero_reg[k][l];
                    if (!y_reg[k][l][CW-1])
                    begin
                        x_reg[k+1][l] <= x_reg[k][l] + (y_reg[k][l] >>> k);
                        y_reg[k+1][l] <= y_reg[k][l] - (x_reg[k][l] >>> k);
                        z_reg[k+1][l] <= z_reg[k][l] + ANGLE;
                    end
                    else
                    begin
                        x_reg[k+1][l] <= x_reg[k][l] - (y_reg[k][l] >>> k);
                        y_reg[k+1][l] <= y_reg[k][l] + (x_reg[k][l] >>> k);
                        z_reg[k+1][l] <= z_reg[k][l] - ANGLE;
                    end
                end
            end
        end
    end

    assign out_valid = valid_reg[STAGES];
    assign out_tag   = tag_reg[STAGES];
    assign out_z[0]  = zero_reg[STAGES][0] ? '0 : z_reg[STAGES][0];
    assign out_z[1]  = zero_reg[STAGES][1] ? '0 : z_reg[STAGES][1];

endmodule

// ----- rtl/core/e2c_map.sv -----
module e2c_map
    import e2c_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 in_valid,
    input  in_item_t             in_tag,
    input  logic signed [ZW-1:0] in_phi,
    input  logic signed [ZW-1:0] in_theta,
    input  cfg_t                 cfg,
    output logic                 out_valid,
    output out_item_t            out_item
);

    localparam logic signed [ZW+1:0] HALF_X    = (ZW+2)'(2 ** (TURN_W - 1));
    localparam logic signed [ZW+1:0] QUARTER_X = (ZW+2)'(2 ** (TURN_W - 2));
    localparam logic signed [ZW+1:0] SAT_HI    = (ZW+2)'(2 ** TURN_W - 1);

    logic                 m1_valid_reg;
    in_item_t             m1_tag_reg;
    logic [TURN_W-1:0]    u24_reg;
    logic [TURN_W-1:0]    v24_reg;
    logic                 m2_valid_reg;
    in_item_t             m2_tag_reg;
    logic [MUL_W-1:0]     bigu_reg;
    logic [MUL_W-1:0]     bigv_reg;
    logic                 m3_valid_reg;
    out_item_t            m3_item_reg;

    logic signed [ZW+1:0] u_sum;
    logic signed [ZW+1:0] v_sum;
    logic [SRC_W-1:0]     u1;
    logic [SRC_W-1:0]     v1;
    logic [SRC_W-1:0]     wm1;
    logic [SRC_W-1:0]     hm1;
    logic [SRC_W-1:0]     u2;
    logic [SRC_W-1:0]     v2;

    function automatic logic [TURN_W-1:0] sat_unit(input logic signed [ZW+1:0] val);
        logic [TURN_W-1:0] res;
        if (val[ZW+1])
            res = '0;
        else if (val > SAT_HI)
            res = '1;
        else
            res = val[TURN_W-1:0];
        return res;
    endfunction

    // Turn the angles into unit fractions
    assign u_sum = {{2{in_phi[ZW-1]}}, in_phi} + HALF_X;
    assign v_sum = (QUARTER_X - {{2{in_theta[ZW-1]}}, in_theta}) <<< 1;

    // Split into integer pixel and fraction, clamp the far neighbour
    assign u1  = bigu_reg[MUL_W-1:TURN_W];
    assign v1  = bigv_reg[MUL_W-1:TURN_W];
    assign wm1 = cfg.w_eff - SRC_W'(1);
    assign hm1 = cfg.h_eff - SRC_W'(1);
    assign u2  = (u1 >= wm1) ? wm1 : u1 + SRC_W'(1);
    assign v2  = (v1 >= hm1) ? hm1 : v1 + SRC_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
            m3_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            m1_valid_reg <= in_valid;
            m2_valid_reg <= m1_valid_reg;
            m3_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            m1_tag_reg <= in_tag;
            u24_reg    <= sat_unit(u_sum);
            v24_reg    <= sat_unit(v_sum);

            m2_tag_reg <= m1_tag_reg;
            bigu_reg   <= MUL_W'(u24_reg) * MUL_W'(cfg.w_eff);
            bigv_reg   <= MUL_W'(v24_reg) * MUL_W'(cfg.h_eff);

            m3_item_reg.out_face <= m2_tag_reg.face;
            m3_item_reg.out_col  <= m2_tag_reg.col;
            m3_item_reg.out_row  <= m2_tag_reg.row;
            m3_item_reg.u_near   <= u1[ADDR_W-1:0];
            m3_item_reg.u_far    <= u2[ADDR_W-1:0];
            m3_item_reg.v_near   <= v1[ADDR_W-1:0];
            m3_item_reg.v_far    <= v2[ADDR_W-1:0];
            m3_item_reg.s_weight <= bigu_reg[TURN_W-1:TURN_W-WEIGHT_W];
            m3_item_reg.t_weight <= bigv_reg[TURN_W-1:TURN_W-WEIGHT_W];
        end
    end

    assign out_valid = m3_valid_reg;
    assign out_item  = m3_item_reg;

endmodule

// ----- tb/tb_equirect_to_cubemap_sample_address.sv -----
module tb_equirect_to_cubemap_sample_address;
    import e2c_pkg::*;

    localparam int STAGES     = 16;
    localparam int WIDTH_MAX  = 4096;
    localparam int LATENCY    = STAGES + 49;
    localparam int CYCLE_CAP  = 600000;
    localparam longint TURN   = 64'd16777216;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    logic      cfg_we;
    cfg_reg_t  cfg_index;
    logic [SRC_W-1:0] cfg_data;

    // Predictor copy of the registers
    logic [SRC_W-1:0] pred_width;
    logic [SRC_W-1:0] pred_height;

    out_item_t expected_addr_q[$];
    int        mismatch_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    equirect_to_cubemap_sample_address u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Arctangent table in units of 2^-24 turn
    function automatic longint atan_step(input int idx);
        longint tbl[24];
        tbl = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
                10430, 5215, 2608, 1304, 652, 326, 163, 81,
                41, 20, 10, 5, 3, 1, 1, 0};
        return tbl[idx];
    endfunction

    // Floor shift; >>> on a signed longint is arithmetic
    function automatic longint fshift(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint vector_angle(input longint y, input longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            z = (y >= 0) ? TURN / 2 : -(TURN / 2);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z += atan_step(i);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z -= atan_step(i);
            end
        end
        return z;
    endfunction

    function automatic longint sat24(input longint v);
        if (v < 0)
            return 0;
        if (v > TURN - 1)
            return TURN - 1;
        return v;
    endfunction

    function automatic out_item_t sample_address(input in_item_t it);
        out_item_t o;
        longint w, h, f, cx, cy, a, b, px, py, pz, r, phi, theta;
        longint bu, bv, u1, u2, v1, v2, s, t;
        w = pred_width;
        h = pred_height;
        if (w < 4) w = 4;
        if (w > WIDTH_MAX) w = WIDTH_MAX;
        if (h < 1) h = 1;
        if (h > 4096) h = 4096;
        f  = w >> 2;
        cx = (it.col > f - 1) ? f - 1 : it.col;
        cy = (it.row > f - 1) ? f - 1 : it.row;
        a  = (2 * cx * 65536) / f - 65536;
        b  = (2 * cy * 65536) / f - 65536;
        case (it.face)
            FACE_POS_X: begin px = a;      py = 65536;  pz = -b;     end
            FACE_NEG_X: begin px = -a;     py = -65536; pz = -b;     end
            FACE_POS_Y: begin px = -b;     py = a;      pz = 65536;  end
            FACE_NEG_Y: begin px = b;      py = a;      pz = -65536; end
            FACE_POS_Z: begin px = -65536; py = a;      pz = -b;     end
            default:    begin px = 65536;  py = -a;     pz = -b;     end
        endcase
        px *= 256;
        py *= 256;
        pz *= 256;
        r     = isqrt(px * px + py * py);
        phi   = vector_angle(py, px);
        theta = vector_angle(pz, r);
        bu = sat24(phi + TURN / 2) * w;
        bv = sat24((TURN / 4 - theta) * 2) * h;
        u1 = bu >> 24;
        v1 = bv >> 24;
        if (u1 > w - 1) u1 = w - 1;
        if (v1 > h - 1) v1 = h - 1;
        u2 = (u1 + 1 > w - 1) ? w - 1 : u1 + 1;
        v2 = (v1 + 1 > h - 1) ? h - 1 : v1 + 1;
        s  = (bu - u1 * TURN) >> 8;
        t  = (bv - v1 * TURN) >> 8;
        if (s > 65535) s = 65535;
        if (t > 65535) t = 65535;
        o.out_face = it.face;
        o.out_col  = it.col;
        o.out_row  = it.row;
        o.u_near   = u1[11:0];
        o.u_far    = u2[11:0];
        o.v_near   = v1[11:0];
        o.v_far    = v2[11:0];
        o.s_weight = s[15:0];
        o.t_weight = t[15:0];
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        mismatch_count++;
    endtask

    // Check each accepted result beat against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_addr_q.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                e = expected_addr_q.pop_front();
                if (out_data.out_face != e.out_face)
                    report_mismatch("out_face", out_data.out_face, e.out_face);
                if (out_data.out_col != e.out_col)
                    report_mismatch("out_col", out_data.out_col, e.out_col);
                if (out_data.out_row != e.out_row)
                    report_mismatch("out_row", out_data.out_row, e.out_row);
                if (out_data.u_near != e.u_near)
                    report_mismatch("u_near", out_data.u_near, e.u_near);
                if (out_data.u_far != e.u_far)
                    report_mismatch("u_far", out_data.u_far, e.u_far);
                if (out_data.v_near != e.v_near)
                    report_mismatch("v_near", out_data.v_near, e.v_near);
                if (out_data.v_far != e.v_far)
                    report_mismatch("v_far", out_data.v_far, e.v_far);
                if (out_data.s_weight != e.s_weight)
                    report_mismatch("s_weight", out_data.s_weight, e.s_weight);
                if (out_data.t_weight != e.t_weight)
                    report_mismatch("t_weight", out_data.t_weight, e.t_weight);
            end
        end
    end

    // Receiver stalls, changed at the falling edge
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Cycle limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Hold valid across back-to-back beats; drop it only while idling
    task automatic send_texel(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        expected_addr_q.push_back(sample_address(it));
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random(input int n);
        in_item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.face = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
                                                : 3'($urandom_range(5));
            it.col  = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(255));
            it.row  = ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(255));
            send_texel(it);
        end
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (expected_addr_q.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [SRC_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_SRC_WIDTH)
            pred_width = val;
        else
            pred_height = val;
        @(negedge clk);
    endtask

    // Corners, centres, poles, every face and out-of-range fields
    task automatic test_directed();
        in_item_t it;
        int f;
        f = pred_width >> 2;
        for (int fc = 0; fc < 8; fc++)
        begin
            it.face = 3'(fc);
            it.col  = 10'(f / 2);
            it.row  = 10'(f / 2);
            send_texel(it);
        end
        it = '{face: FACE_POS_X, col: 10'd0, row: 10'd0};
        send_texel(it);
        it = '{face: FACE_NEG_X, col: 10'd1023, row: 10'd1023};
        send_texel(it);
        it = '{face: FACE_POS_Y, col: 10'd0, row: 10'd1023};
        send_texel(it);
        it = '{face: FACE_NEG_Y, col: 10'd1023, row: 10'd0};
        send_texel(it);
        it = '{face: FACE_POS_Z, col: 10'(f - 1), row: 10'(f - 1)};
        send_texel(it);
        it = '{face: 3'd5, col: 10'h2AA, row: 10'h155};
        send_texel(it);
        it = '{face: 3'd7, col: 10'h155, row: 10'h2AA};
        send_texel(it);
        drain_pipeline();
    endtask

    task automatic test_default_geometry();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random(200);
        drain_pipeline();
    endtask

    task automatic test_sender_idle();
        send_idle_pct  = 71;
        recv_stall_pct = 0;
        write_reg(REG_SRC_WIDTH, 13'd4);
        write_reg(REG_SRC_HEIGHT, 13'd1);
        send_random(150);
        drain_pipeline();
    endtask

    task automatic test_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 71;
        write_reg(REG_SRC_WIDTH, 13'd4096);
        write_reg(REG_SRC_HEIGHT, 13'd4096);
        test_directed();
        send_random(200);
        drain_pipeline();
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        write_reg(REG_SRC_WIDTH, 13'h1FFF);
        write_reg(REG_SRC_HEIGHT, 13'h1FFF);
        send_random(100);
        drain_pipeline();
        write_reg(REG_SRC_WIDTH, 13'd0);
        write_reg(REG_SRC_HEIGHT, 13'd0);
        send_random(100);
        drain_pipeline();
        write_reg(REG_SRC_WIDTH, 13'($urandom_range(4096, 4)));
        write_reg(REG_SRC_HEIGHT, 13'($urandom_range(4096, 1)));
        send_random(200);
        drain_pipeline();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = REG_SRC_WIDTH;
        cfg_data       = '0;
        pred_width     = 13'(RESET_WIDTH);
        pred_height    = 13'(RESET_HEIGHT);
        mismatch_count = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_default_geometry();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
